### src/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk_i, with and without the reset guard.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TDB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TDB_ASSERT(lbl, prop, msg)
`define TDB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/tdb_pkg.sv
// -----------------------------------------------------------------------------
// Target distance and bearing package
// Widths, constants, pipeline types and the arctangent table.
// -----------------------------------------------------------------------------
package tdb_pkg;

  localparam int COORD_BITS   = 24;
  localparam int FACE_W       = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int ROOT_W       = DIFF_W + 1;
  localparam int SUM_W        = 2 * ROOT_W;
  localparam int REM_W        = ROOT_W + 3;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int PROD_W       = DIFF_W + FACE_W;
  localparam int DOT_W        = PROD_W + 1;
  localparam int MAG_W        = PROD_W;
  localparam int NORM_TOP     = 30;
  localparam int NW           = (MAG_W > NORM_TOP + 1) ? MAG_W : NORM_TOP + 1;
  localparam int NORM_HALF    = 5;
  localparam int NORM_STAGES  = 2 * NORM_HALF;
  localparam int NORM_MAX_SH  = 1 << (NORM_HALF - 1);
  localparam int CW           = 34;
  localparam int ZW           = 25;
  localparam int CORDIC_STEPS = 23;
  localparam int STEP_W       = 5;
  localparam int DIST_W       = 25;
  localparam int BRG_W        = 17;
  localparam int TOL_W        = 8;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int DIST_LIM_LOG = 25;

  localparam logic [DIST_W-1:0]   DIST_MAX  = '1;
  localparam logic [BRG_W-1:0]    BRG_90    = BRG_W'(23040);
  localparam logic [BRG_W-1:0]    BRG_180   = BRG_W'(46080);
  localparam logic signed [ZW-1:0] Z_90     = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Z_180    = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] Z_HALF   = ZW'(128);

  localparam logic [0:0] REG_NEAR_TOL = 1'b0;

  localparam int LB  = 1 + NORM_STAGES + CORDIC_STEPS + 1;
  localparam int LS  = ROOT_W + 1;
  localparam int LAT = (LB > LS) ? LB : LS;

  typedef struct packed {
    logic              fixed;
    logic              neg;
    logic              dneg;
    logic [BRG_W-1:0]  fval;
  } brg_ctl_t;

  typedef struct packed {
    brg_ctl_t          ctl;
    logic [NW-1:0]     x;
    logic [NW-1:0]     y;
  } norm_t;

  typedef struct packed {
    brg_ctl_t               ctl;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } cord_t;

  typedef struct packed {
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
  } sqrt_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = ZW'(2949120);
      5'd1:    a = ZW'(1740967);
      5'd2:    a = ZW'(919879);
      5'd3:    a = ZW'(466945);
      5'd4:    a = ZW'(234379);
      5'd5:    a = ZW'(117304);
      5'd6:    a = ZW'(58666);
      5'd7:    a = ZW'(29335);
      5'd8:    a = ZW'(14668);
      5'd9:    a = ZW'(7334);
      5'd10:   a = ZW'(3667);
      5'd11:   a = ZW'(1833);
      5'd12:   a = ZW'(917);
      5'd13:   a = ZW'(458);
      5'd14:   a = ZW'(229);
      5'd15:   a = ZW'(115);
      5'd16:   a = ZW'(57);
      5'd17:   a = ZW'(29);
      5'd18:   a = ZW'(14);
      5'd19:   a = ZW'(7);
      5'd20:   a = ZW'(4);
      5'd21:   a = ZW'(2);
      5'd22:   a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/tdb_sqrt_cell.sv
// -----------------------------------------------------------------------------
// Square root cell
// One restoring digit step: two radicand bits in, one root bit out.
// -----------------------------------------------------------------------------
module tdb_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  tdb_pkg::sqrt_t  sq_i,
  output tdb_pkg::sqrt_t  sq_o
);
  import tdb_pkg::*;

  logic [REM_W-1:0] cand;
  logic [REM_W-1:0] trial;
  logic             ge;
  sqrt_t            sq_d;
  sqrt_t            sq_q;

  always_comb begin
    cand      = {sq_i.rem[REM_W-3:0], sq_i.rad[SUM_W-1 -: 2]};
    trial     = REM_W'({sq_i.root, 2'b01});
    ge        = cand >= trial;
    sq_d.sat  = sq_i.sat;
    sq_d.rem  = ge ? cand - trial : cand;
    sq_d.root = {sq_i.root[ROOT_W-2:0], ge};
    sq_d.rad  = {sq_i.rad[SUM_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

### src/tdb_cordic_cell.sv
// -----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation with its arctangent step.
// -----------------------------------------------------------------------------
module tdb_cordic_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tdb_pkg::STEP_W-1:0]    step_i,
  input  tdb_pkg::cord_t                cord_i,
  output tdb_pkg::cord_t                cord_o
);
  import tdb_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;
  cord_t                cord_d;
  cord_t                cord_q;

  always_comb begin
    xs         = cord_i.x >>> step_i;
    ys         = cord_i.y >>> step_i;
    at         = atan_q16(step_i);
    cord_d.ctl = cord_i.ctl;
    if (!cord_i.y[CW-1]) begin
      cord_d.x = cord_i.x + ys;
      cord_d.y = cord_i.y - xs;
      cord_d.z = cord_i.z + at;
    end else begin
      cord_d.x = cord_i.x - ys;
      cord_d.y = cord_i.y + xs;
      cord_d.z = cord_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

### src/target_distance_and_bearing.sv
// Throughput: one item per cycle while in_stall_o is low; the 35-stage bearing
// chain (10 normalize stages and 23 CORDIC cells) sets the depth, and the 26-cell
// root chain runs beside it.
// A skid register behind the output register takes one result during a stall.
// Reset clears all valid bits and the tolerance register; payload is not reset.
// -----------------------------------------------------------------------------
// Target distance and bearing
// Pipelined 3-D distance and signed planar bearing to a target.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module target_distance_and_bearing (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tdb_pkg::PADDR_W-1:0]            paddr,
  input  logic [tdb_pkg::PDATA_W-1:0]            pwdata,
  output logic [tdb_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   target_present_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  self_x_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  self_y_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  self_z_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  target_x_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  target_y_i,
  input  logic signed [tdb_pkg::COORD_BITS-1:0]  target_z_i,
  input  logic signed [tdb_pkg::FACE_W-1:0]      facing_x_i,
  input  logic signed [tdb_pkg::FACE_W-1:0]      facing_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [tdb_pkg::DIST_W-1:0]             distance_o,
  output logic signed [tdb_pkg::BRG_W-1:0]       bearing_o
);
  import tdb_pkg::*;

  localparam int BPAD = LAT - LB;
  localparam int SPAD = LAT - LS;
  localparam logic [63:0] DIST_LIM = 64'd1 << DIST_LIM_LOG;
  localparam logic signed [BRG_W-1:0] BRG_LIMIT = BRG_180;

  logic             en;
  logic [TOL_W-1:0] tol_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEAR_TOL) ? PDATA_W'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NEAR_TOL)) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // stage 1: offsets
  logic                     s1_vld_q;
  logic                     s1_pres_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [FACE_W-1:0] fx_q, fy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pres_q <= target_present_i;
      dx_q <= DIFF_W'(target_x_i) - DIFF_W'(self_x_i);
      dy_q <= DIFF_W'(target_y_i) - DIFF_W'(self_y_i);
      dz_q <= DIFF_W'(target_z_i) - DIFF_W'(self_z_i);
      fx_q <= facing_x_i;
      fy_q <= facing_y_i;
    end
  end

  // stage 2: products and flags
  logic [DIFF_W-1:0]        ax, ay, az;
  logic                     s2_vld_q;
  logic                     s2_pres_q, s2_near_q, s2_fzero_q, s2_sat_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q, sqz_q;
  logic signed [PROD_W-1:0] p_fxdx_q, p_fydy_q, p_fxdy_q, p_fydx_q;

  always_comb begin
    ax = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    ay = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    az = dz_q[DIFF_W-1] ? DIFF_W'(-dz_q) : DIFF_W'(dz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pres_q  <= s1_pres_q;
      s2_near_q  <= (ax <= DIFF_W'(tol_q)) && (ay <= DIFF_W'(tol_q));
      s2_fzero_q <= (fx_q == '0) && (fy_q == '0);
      s2_sat_q   <= (64'(ax) >= DIST_LIM) || (64'(ay) >= DIST_LIM) ||
                    (64'(az) >= DIST_LIM);
      sqx_q      <= SQ_W'(ax) * SQ_W'(ax);
      sqy_q      <= SQ_W'(ay) * SQ_W'(ay);
      sqz_q      <= SQ_W'(az) * SQ_W'(az);
      p_fxdx_q   <= PROD_W'(fx_q) * PROD_W'(dx_q);
      p_fydy_q   <= PROD_W'(fy_q) * PROD_W'(dy_q);
      p_fxdy_q   <= PROD_W'(fx_q) * PROD_W'(dy_q);
      p_fydx_q   <= PROD_W'(fy_q) * PROD_W'(dx_q);
    end
  end

  // stage 3: sums
  logic                     vld_q [0:LAT];
  logic                     s3_pres_q, s3_near_q, s3_fzero_q;
  logic signed [DOT_W-1:0]  dot_q, cross_q;
  sqrt_t                    sq_s [0:ROOT_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pres_q  <= s2_pres_q;
      s3_near_q  <= s2_near_q;
      s3_fzero_q <= s2_fzero_q;
      dot_q      <= DOT_W'(p_fxdx_q) + DOT_W'(p_fydy_q);
      cross_q    <= DOT_W'(p_fxdy_q) - DOT_W'(p_fydx_q);
      sq_s[0].sat  <= s2_sat_q && s2_pres_q;
      sq_s[0].rem  <= '0;
      sq_s[0].root <= '0;
      sq_s[0].rad  <= s2_pres_q ?
                      (SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q)) : '0;
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      for (int k = 0; k <= LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      vld_q[0] <= s2_vld_q;
      for (int k = 1; k <= LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // root chain
  logic [ROOT_W:0]   root_r;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] spad [0:SPAD];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tdb_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq_s[k]),
      .sq_o  (sq_s[k+1])
    );
  end

  assign root_r = (ROOT_W+1)'(sq_s[ROOT_W].root) +
                  (ROOT_W+1)'(REM_W'(sq_s[ROOT_W].rem) > REM_W'(sq_s[ROOT_W].root));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sq_s[ROOT_W].sat || (64'(root_r) > 64'(DIST_MAX))) begin
        dist_q <= DIST_MAX;
      end else begin
        dist_q <= DIST_W'(root_r);
      end
    end
  end

  assign spad[0] = dist_q;
  for (genvar k = 0; k < SPAD; k++) begin : g_spad
    always_ff @(posedge clk_i) begin
      if (en) begin
        spad[k+1] <= spad[k];
      end
    end
  end

  // bearing setup
  norm_t              norm_s [0:NORM_STAGES];
  brg_ctl_t           ctl0;
  logic               dneg, cpos;
  logic [MAG_W-1:0]   mdot, mcross;

  always_comb begin
    dneg   = dot_q[DOT_W-1];
    cpos   = !cross_q[DOT_W-1] && (cross_q != '0);
    mdot   = dneg ? MAG_W'(-dot_q) : MAG_W'(dot_q);
    mcross = cross_q[DOT_W-1] ? MAG_W'(-cross_q) : MAG_W'(cross_q);
    ctl0.dneg  = dneg;
    ctl0.fixed = 1'b1;
    ctl0.neg   = 1'b0;
    ctl0.fval  = '0;
    if (!s3_pres_q || s3_near_q) begin
      ctl0.fval = '0;
    end else if (s3_fzero_q) begin
      ctl0.fval = BRG_90;
    end else if (cross_q == '0) begin
      ctl0.fval = dneg ? BRG_180 : '0;
    end else if (dot_q == '0) begin
      ctl0.fval = BRG_90;
      ctl0.neg  = cpos;
    end else begin
      ctl0.fixed = 1'b0;
      ctl0.neg   = cpos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_s[0].ctl <= ctl0;
      norm_s[0].x   <= NW'(mdot);
      norm_s[0].y   <= NW'(mcross);
    end
  end

  // normalize: right shifts first, then left shifts
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam bit RIGHT = (k < NORM_HALF);
    localparam int AMT   = RIGHT ? (NORM_MAX_SH >> k) : (NORM_MAX_SH >> (k - NORM_HALF));
    logic [NW-1:0] hi;
    logic          go;

    always_comb begin
      hi = (norm_s[k].x > norm_s[k].y) ? norm_s[k].x : norm_s[k].y;
      if (RIGHT) begin
        go = 64'(hi) >= (64'd1 << (NORM_TOP - 1 + AMT));
      end else begin
        go = 64'(hi) < (64'd1 << (NORM_TOP - AMT));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        norm_s[k+1].ctl <= norm_s[k].ctl;
        if (!go) begin
          norm_s[k+1].x <= norm_s[k].x;
          norm_s[k+1].y <= norm_s[k].y;
        end else if (RIGHT) begin
          norm_s[k+1].x <= norm_s[k].x >> AMT;
          norm_s[k+1].y <= norm_s[k].y >> AMT;
        end else begin
          norm_s[k+1].x <= norm_s[k].x << AMT;
          norm_s[k+1].y <= norm_s[k].y << AMT;
        end
      end
    end
  end

  // CORDIC chain
  cord_t cord_s [0:CORDIC_STEPS];

  always_comb begin
    cord_s[0].ctl = norm_s[NORM_STAGES].ctl;
    cord_s[0].x   = $signed({{(CW-NORM_TOP){1'b0}}, norm_s[NORM_STAGES].x[NORM_TOP-1:0]});
    cord_s[0].y   = $signed({{(CW-NORM_TOP){1'b0}}, norm_s[NORM_STAGES].y[NORM_TOP-1:0]});
    cord_s[0].z   = '0;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    tdb_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (STEP_W'(k)),
      .cord_i (cord_s[k]),
      .cord_o (cord_s[k+1])
    );
  end

  // bearing finish
  cord_t                   cf;
  logic signed [ZW-1:0]    zc;
  logic signed [ZW-1:0]    zr;
  logic [BRG_W-1:0]        bmag;
  logic signed [BRG_W-1:0] brg_q;
  logic signed [BRG_W-1:0] bpad [0:BPAD];

  always_comb begin
    cf = cord_s[CORDIC_STEPS];
    if (cf.z[ZW-1]) begin
      zc = '0;
    end else if (cf.z > Z_90) begin
      zc = Z_90;
    end else begin
      zc = cf.z;
    end
    if (cf.ctl.dneg) begin
      zc = Z_180 - zc;
    end
    zr   = (zc + Z_HALF) >>> 8;
    bmag = cf.ctl.fixed ? cf.ctl.fval : BRG_W'(zr);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      brg_q <= cf.ctl.neg ? -$signed(bmag) : $signed(bmag);
    end
  end

  assign bpad[0] = brg_q;
  for (genvar k = 0; k < BPAD; k++) begin : g_bpad
    always_ff @(posedge clk_i) begin
      if (en) begin
        bpad[k+1] <= bpad[k];
      end
    end
  end

  // output register and skid
  logic                    out_vld_q, skid_vld_q, take;
  logic [DIST_W-1:0]       out_dist_q, skid_dist_q;
  logic signed [BRG_W-1:0] out_brg_q, skid_brg_q;

  assign take = out_vld_q && !out_stall_i;
  assign en   = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || take) begin
      out_vld_q <= vld_q[LAT];
    end else if (vld_q[LAT]) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_dist_q <= skid_dist_q;
        out_brg_q  <= skid_brg_q;
      end
    end else if (!out_vld_q || take) begin
      out_dist_q <= spad[SPAD];
      out_brg_q  <= bpad[BPAD];
    end else begin
      skid_dist_q <= spad[SPAD];
      skid_brg_q  <= bpad[BPAD];
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign distance_o  = out_dist_q;
  assign bearing_o   = out_brg_q;

  `TDB_ASSERT_ALWAYS(a_skid_has_out, skid_vld_q |-> out_vld_q, "skid full without output")
  `TDB_ASSERT(a_skid_fill, $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i), "bad skid fill")
  `TDB_ASSERT(a_brg_range, out_vld_q |-> (out_brg_q <= BRG_LIMIT && out_brg_q >= -BRG_LIMIT), "bearing range")
  `TDB_ASSERT(a_no_accept_full, $past(skid_vld_q) |-> $stable(vld_q[LAT]), "pipeline moved while full")

endmodule
